@@ src/ues_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ues_pkg
// Shared types, constants and helpers for the ultrasonic echo scanner.
// ----------------------------------------------------------------------------
package ues_pkg;

    localparam int NUM_SENSORS = 16;
    localparam int IDX_W       = $clog2(NUM_SENSORS);
    localparam int MAX_WIDTH   = 511;
    localparam int WIDTH_W     = $clog2(MAX_WIDTH + 1);
    localparam int GAP_W       = 16;
    localparam int TRIG_W      = 4;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [GAP_W-1:0]   WAIT_LIMIT = 16'd65534;
    localparam logic [GAP_W-1:0]   GAP_MAX    = 16'd65535;
    localparam logic [GAP_W-1:0]   WAIT_RESET = 16'd200;
    localparam logic [WIDTH_W-1:0] WIDTH_MAX  = WIDTH_W'(MAX_WIDTH);

    // register indexes of the configuration port
    localparam logic [CFG_IDX_W-1:0] CFG_ENABLE_MASK = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TRIGGER_MAP = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_WAIT_TICKS  = 2'd2;

    typedef enum logic [2:0] {
        PH_TRIG_START = 3'd0,
        PH_TRIG_END   = 3'd1,
        PH_WAIT_RISE  = 3'd2,
        PH_COUNT      = 3'd3,
        PH_GAP        = 3'd4
    } t_phase;

    typedef struct packed {
        logic [NUM_SENSORS-1:0] echo_levels;
        logic [IDX_W-1:0]       read_index;
    } t_in_item;

    typedef struct packed {
        logic               trigger_high;
        logic [TRIG_W-1:0]  trigger_index;
        logic [WIDTH_W-1:0] read_width;
        logic               measure_done;
        logic [IDX_W-1:0]   done_sensor;
        logic [WIDTH_W-1:0] done_width;
    } t_out_item;

    typedef struct packed {
        logic             found;
        logic [IDX_W-1:0] idx;
    } t_pick;

    // Next enabled sensor after cur, wrapping, cur itself checked last.
    function automatic t_pick pick_after(input logic [NUM_SENSORS-1:0] mask,
                                         input logic [IDX_W-1:0] cur);
        logic [2*NUM_SENSORS-1:0] dbl;
        logic [NUM_SENSORS-1:0]   rot;
        logic [IDX_W:0]           start;
        t_pick                    p;
        dbl     = {mask, mask};
        start   = {1'b0, cur} + (IDX_W+1)'(1);
        rot     = dbl[start +: NUM_SENSORS];
        p.found = |rot;
        p.idx   = cur;
        for (int i = NUM_SENSORS - 1; i >= 0; i--) begin
            if (rot[i]) begin
                p.idx = IDX_W'((int'(cur) + 1 + i) % NUM_SENSORS);
            end
        end
        return p;
    endfunction

endpackage

@@ src/ues_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ues_in_if
// Input channel: one sampled tick per transaction.
// ----------------------------------------------------------------------------
interface ues_in_if;
    logic               valid;
    logic               ready;
    ues_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ues_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ues_out_if
// Result channel: one result per accepted tick.
// ----------------------------------------------------------------------------
interface ues_out_if;
    logic               valid;
    logic               ready;
    ues_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

@@ src/ultrasonic_echo_scanner_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ultrasonic_echo_scanner_unit
// Round-robin ultrasonic rangefinder scanner: triggers, times echoes, stores
// per-sensor widths.
// ----------------------------------------------------------------------------
// One input transaction is one tick of the sensor sequencer and yields exactly
// one result transaction. The block takes a tick every clock cycle while the
// skid entry is empty. A tick is held in the input register and its result is
// loaded into the result register, or into the skid entry while the result
// register waits on the sink. That rate rests on combinational next-state
// logic: the 16-bit rotate priority pick of the next enabled sensor and the
// width store update both happen in the step for that tick. A two-entry
// output buffer (result register plus skid) lets the sequencer process one
// more tick while a result waits on the sink. The width store resets to 511
// for every sensor at once; no clearing sweep. Configuration is written
// through a plain write port and takes effect on the next tick processed.
// ----------------------------------------------------------------------------
module ultrasonic_echo_scanner_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [ues_pkg::CFG_IDX_W-1:0]       i_cfg_index,
    input  logic [ues_pkg::CFG_DATA_W-1:0]      i_cfg_data,
    ues_in_if.sink                              i_in,
    ues_out_if.source                           o_out
);

    localparam int N  = ues_pkg::NUM_SENSORS;
    localparam int IW = ues_pkg::IDX_W;
    localparam int WW = ues_pkg::WIDTH_W;
    localparam int GW = ues_pkg::GAP_W;
    localparam int TW = ues_pkg::TRIG_W;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [N-1:0]                       r_enable_mask;
    logic [ues_pkg::CFG_DATA_W-1:0]     r_trigger_map;
    logic [GW-1:0]                      r_wait_ticks;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable_mask <= '0;
            r_trigger_map <= '0;
            r_wait_ticks  <= ues_pkg::WAIT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                ues_pkg::CFG_ENABLE_MASK: r_enable_mask <= i_cfg_data[N-1:0];
                ues_pkg::CFG_TRIGGER_MAP: r_trigger_map <= i_cfg_data;
                ues_pkg::CFG_WAIT_TICKS:  r_wait_ticks  <= i_cfg_data[GW-1:0];
                default: ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Input register and flow control
    // ------------------------------------------------------------------
    logic               r_in_valid;
    ues_pkg::t_in_item  r_in_data;
    logic               r_out_valid;
    ues_pkg::t_out_item r_out_data;
    logic               r_skid_valid;
    ues_pkg::t_out_item r_skid_data;

    logic in_take;
    logic advance;      // tick in the input register is processed this cycle
    logic out_take;

    // The skid entry is the only thing that can block the sequencer step.
    assign advance    = r_in_valid && !r_skid_valid;
    assign i_in.ready = !r_in_valid || !r_skid_valid;
    assign in_take    = i_in.valid && i_in.ready;
    assign out_take   = r_out_valid && o_out.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_data <= i_in.data;
        end
    end

    // ------------------------------------------------------------------
    // Sequencer state
    // ------------------------------------------------------------------
    ues_pkg::t_phase    r_phase, n_phase;
    logic [IW-1:0]      r_cur, n_cur;
    logic [GW-1:0]      r_gap, n_gap;
    logic [WW-1:0]      r_pulse, n_pulse;
    logic               r_echo_prev, n_echo_prev;
    logic [WW-1:0]      r_store [N];

    logic               store_we;
    logic               trig;
    logic [GW-1:0]      eff_wait;
    logic [GW-1:0]      gap_inc;
    logic               gap_over;
    logic               echo_bit;
    logic [WW-1:0]      pulse_inc;
    ues_pkg::t_pick     pick;

    assign eff_wait  = (r_wait_ticks > ues_pkg::WAIT_LIMIT) ? ues_pkg::WAIT_LIMIT
                                                              : r_wait_ticks;
    // saturating gap counter step and its timeout compare
    assign gap_inc   = (r_gap < ues_pkg::GAP_MAX) ? r_gap + GW'(1) : r_gap;
    assign gap_over  = gap_inc > eff_wait;
    assign echo_bit  = r_in_data.echo_levels[r_cur];
    assign pulse_inc = (r_pulse < ues_pkg::WIDTH_MAX) ? r_pulse + WW'(1)
                                                       : ues_pkg::WIDTH_MAX;
    assign pick      = ues_pkg::pick_after(r_enable_mask, r_cur);

    // next-state logic
    always_comb begin
        n_phase     = r_phase;
        n_cur       = r_cur;
        n_gap       = r_gap;
        n_pulse     = r_pulse;
        n_echo_prev = r_echo_prev;
        unique case (r_phase)
            ues_pkg::PH_TRIG_START: begin
                // disabled current sensor: jump to the next enabled one
                if (r_enable_mask[r_cur]) begin
                    n_phase = ues_pkg::PH_TRIG_END;
                end else if (pick.found) begin
                    n_cur   = pick.idx;
                    n_phase = ues_pkg::PH_TRIG_END;
                end
            end
            ues_pkg::PH_TRIG_END: begin
                n_echo_prev = 1'b0;
                n_phase     = ues_pkg::PH_WAIT_RISE;
            end
            ues_pkg::PH_WAIT_RISE: begin
                if (echo_bit && !r_echo_prev) begin
                    n_pulse = '0;
                    n_gap   = '0;
                    n_phase = ues_pkg::PH_COUNT;
                end else begin
                    n_gap = gap_inc;
                    if (gap_over) begin
                        n_phase = ues_pkg::PH_GAP;
                    end
                end
                n_echo_prev = echo_bit;
            end
            ues_pkg::PH_COUNT: begin
                n_pulse = pulse_inc;
                if (!echo_bit && r_echo_prev) begin
                    n_gap   = '0;
                    n_phase = ues_pkg::PH_GAP;
                end else begin
                    // timeout keeps the gap count, so the gap ends next tick
                    n_gap = gap_inc;
                    if (gap_over) begin
                        n_phase = ues_pkg::PH_GAP;
                    end
                end
                n_echo_prev = echo_bit;
            end
            ues_pkg::PH_GAP: begin
                n_gap = gap_inc;
                if (gap_over) begin
                    if (pick.found) begin
                        n_cur = pick.idx;
                    end
                    n_gap   = '0;
                    n_phase = ues_pkg::PH_TRIG_START;
                end
            end
            default: begin
                n_gap   = '0;
                n_phase = ues_pkg::PH_TRIG_START;
            end
        endcase
    end

    // output decode for the current tick
    always_comb begin
        trig     = 1'b0;
        store_we = 1'b0;
        unique case (r_phase)
            ues_pkg::PH_TRIG_START: trig     = r_enable_mask[r_cur] || pick.found;
            ues_pkg::PH_COUNT:      store_we = !echo_bit && r_echo_prev;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= ues_pkg::PH_TRIG_START;
            r_cur       <= '0;
            r_gap       <= '0;
            r_pulse     <= '0;
            r_echo_prev <= 1'b0;
        end else if (advance) begin
            r_phase     <= n_phase;
            r_cur       <= n_cur;
            r_gap       <= n_gap;
            r_pulse     <= n_pulse;
            r_echo_prev <= n_echo_prev;
        end
    end

    // width store: every entry reads 511 until measured
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < N; i++) begin
                r_store[i] <= ues_pkg::WIDTH_MAX;
            end
        end else if (advance && store_we) begin
            r_store[r_cur] <= pulse_inc;
        end
    end

    // ------------------------------------------------------------------
    // Result assembly
    // ------------------------------------------------------------------
    ues_pkg::t_out_item res;

    always_comb begin
        res.trigger_high  = trig;
        res.trigger_index = r_trigger_map[n_cur * TW +: TW];
        // read sees this tick's store write
        if (store_we && (r_in_data.read_index == r_cur)) begin
            res.read_width = pulse_inc;
        end else begin
            res.read_width = r_store[r_in_data.read_index];
        end
        res.measure_done  = store_we;
        res.done_sensor   = store_we ? r_cur : '0;
        res.done_width    = store_we ? pulse_inc : '0;
    end

    // ------------------------------------------------------------------
    // Result register plus skid entry
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_take) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= advance;
            end
        end else if (advance) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_take) begin
            r_out_data <= r_skid_valid ? r_skid_data : res;
        end else if (advance) begin
            r_skid_data <= res;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out_data;

endmodule

@@ src/ues_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ues_checker
// Port-level checks on the scanner result channel.
// ----------------------------------------------------------------------------
module ues_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input ues_pkg::t_out_item i_out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed while stalled");

    // trigger tick and store tick are different phases
    a_trig_vs_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !(i_out_data.trigger_high && i_out_data.measure_done))
        else $error("trigger and measurement on one tick");

    // done fields are zero unless a width was stored
    a_done_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_data.measure_done
            |-> i_out_data.done_sensor == '0 && i_out_data.done_width == '0)
        else $error("done fields set without measurement");

    // a stored width counts at least one tick
    a_done_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_data.measure_done |-> i_out_data.done_width != '0)
        else $error("zero width stored");

endmodule

bind ultrasonic_echo_scanner_unit ues_checker u_ues_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_out.valid),
    .i_out_ready (o_out.ready),
    .i_out_data  (o_out.data)
);
